// ===== hw/rtl/tlcc_pkg.sv =====
// Package for the traffic light countdown controller.
// Holds event codes, config indexes, reset values, phase bounds, light patterns and digit helpers.
// No dependencies.
`default_nettype none

package tlcc_pkg;

    // Event codes carried in the operation field.
    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_MODE    = 2'd1;
    localparam logic [1:0] OP_PATTERN = 2'd2;

    // Configuration register indexes.
    localparam logic CFG_TICKS_PER_SECOND = 1'b0;
    localparam logic CFG_CYCLE_START      = 1'b1;

    // Reset values.
    localparam logic [15:0] TICKS_PER_SECOND_RST = 16'd1000;
    localparam logic [6:0]  CYCLE_START_RST      = 7'd21;

    // Phase boundaries and digit offsets.
    localparam logic [6:0] PHASE_AMBER_HI = 7'd13;
    localparam logic [6:0] PHASE_AMBER_LO = 7'd10;
    localparam logic [6:0] PHASE_LOW      = 7'd3;
    localparam logic [6:0] OFFSET_FIRST   = 7'd11;
    localparam logic [6:0] OFFSET_SECOND  = 7'd14;

    // Light patterns.
    localparam logic [7:0] PAT_FIRST_GO  = 8'h81;
    localparam logic [7:0] PAT_FIRST_AMB = 8'h41;
    localparam logic [7:0] PAT_SECOND_GO = 8'h24;
    localparam logic [7:0] PAT_SECOND_AMB = 8'h22;

    // Tens digit of a value below 128 by multiplying with 205/2048,
    // which is exact for all values below about one thousand.
    function automatic logic [3:0] f_tens(input logic [6:0] v);
        logic [14:0] p;
        p = 15'(v) * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] f_ones(input logic [6:0] v);
        logic [6:0] t;
        t = 7'(f_tens(v)) * 7'd10;
        return 4'(v - t);
    endfunction

    // Hex segment glyphs, so tens digits of ten and above still show a symbol.
    function automatic logic [6:0] f_seg(input logic [3:0] d);
        logic [6:0] s;
        case (d)
            4'd0:    s = 7'h3f;
            4'd1:    s = 7'h06;
            4'd2:    s = 7'h5b;
            4'd3:    s = 7'h4f;
            4'd4:    s = 7'h66;
            4'd5:    s = 7'h6d;
            4'd6:    s = 7'h7d;
            4'd7:    s = 7'h07;
            4'd8:    s = 7'h7f;
            4'd9:    s = 7'h6f;
            4'd10:   s = 7'h77;
            4'd11:   s = 7'h7c;
            4'd12:   s = 7'h39;
            4'd13:   s = 7'h5e;
            4'd14:   s = 7'h79;
            default: s = 7'h71;
        endcase
        return s;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/traffic_light_countdown_controller.sv =====
// Traffic light countdown controller: event in, light pattern and countdown digits out.
// Depends on tlcc_pkg.
//
// Channel   Direction  Handshake                     Payload
// input     in         i_in_valid / o_in_ready       i_operation, i_pattern_pressed
// result    out        o_out_valid / i_out_ready     o_light_pattern, o_seg_*, o_manual_mode,
//                                                    o_seconds_left
// config    in         i_cfg_we (no wait)            i_cfg_addr, i_cfg_data
//
// Each word is processed combinationally: the state update and the digit decode sit
// between the state registers and the result register, so one word per cycle
// flows through while results are taken, each result registered in the cycle after its word.
// Synchronous reset clears the state to its power-up values and empties the result.
// When the result register is full and not taken, o_in_ready drops until it is.
`default_nettype none

module traffic_light_countdown_controller (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_addr,
    input  wire logic [15:0] i_cfg_data,
    input  wire logic        i_in_valid,
    output      logic        o_in_ready,
    input  wire logic [1:0]  i_operation,
    input  wire logic        i_pattern_pressed,
    output      logic        o_out_valid,
    input  wire logic        i_out_ready,
    output      logic [7:0]  o_light_pattern,
    output      logic [6:0]  o_seg_tens_first,
    output      logic [6:0]  o_seg_ones_first,
    output      logic [6:0]  o_seg_tens_second,
    output      logic [6:0]  o_seg_ones_second,
    output      logic        o_manual_mode,
    output      logic [6:0]  o_seconds_left
);

    logic [15:0] r_ticks_per_second;
    logic [6:0]  r_cycle_start;
    logic [15:0] r_tick_counter, n_tick_counter;
    logic [6:0]  r_countdown, n_countdown;
    logic        r_manual, n_manual;
    logic [7:0]  r_manual_pattern, n_manual_pattern;
    logic        r_button_was_pressed, n_button_was_pressed;

    logic        r_out_valid;
    logic [7:0]  r_light_pattern, n_light_pattern;
    logic [6:0]  r_seg_tf, n_seg_tf;
    logic [6:0]  r_seg_of, n_seg_of;
    logic [6:0]  r_seg_ts, n_seg_ts;
    logic [6:0]  r_seg_os, n_seg_os;

    logic        in_accept;
    logic [15:0] tick_inc;
    logic [7:0]  auto_pattern;
    logic [6:0]  first_val, second_val;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_accept  = i_in_valid && o_in_ready;
    assign tick_inc   = r_tick_counter + 16'd1;

    // Next state for the accepted word.
    always_comb begin
        n_tick_counter       = r_tick_counter;
        n_countdown          = r_countdown;
        n_manual             = r_manual;
        n_manual_pattern     = r_manual_pattern;
        n_button_was_pressed = r_button_was_pressed;
        case (i_operation)
            tlcc_pkg::OP_TICK: begin
                if (!r_manual) begin
                    if (tick_inc >= r_ticks_per_second) begin
                        n_tick_counter = '0;
                        n_countdown    = (r_countdown != 7'd0) ?
                                         r_countdown - 7'd1 : r_cycle_start;
                    end else begin
                        n_tick_counter = tick_inc;
                    end
                end
            end
            tlcc_pkg::OP_MODE: begin
                n_manual = !r_manual;
            end
            tlcc_pkg::OP_PATTERN: begin
                if (r_manual) begin
                    if (i_pattern_pressed && !r_button_was_pressed) begin
                        n_manual_pattern = (r_manual_pattern == tlcc_pkg::PAT_FIRST_GO) ?
                                           tlcc_pkg::PAT_SECOND_GO : tlcc_pkg::PAT_FIRST_GO;
                    end
                    n_button_was_pressed = i_pattern_pressed;
                end
            end
            default: begin
            end
        endcase
    end

    // Phase decode and digit split from the updated countdown.
    always_comb begin
        if (n_countdown > tlcc_pkg::PHASE_AMBER_HI) begin
            auto_pattern = tlcc_pkg::PAT_FIRST_GO;
            first_val    = n_countdown - tlcc_pkg::OFFSET_FIRST;
            second_val   = n_countdown - tlcc_pkg::OFFSET_SECOND;
        end else if (n_countdown > tlcc_pkg::PHASE_AMBER_LO) begin
            auto_pattern = tlcc_pkg::PAT_FIRST_AMB;
            first_val    = n_countdown - tlcc_pkg::OFFSET_FIRST;
            second_val   = first_val;
        end else if (n_countdown >= tlcc_pkg::PHASE_LOW) begin
            auto_pattern = tlcc_pkg::PAT_SECOND_GO;
            first_val    = n_countdown - tlcc_pkg::PHASE_LOW;
            second_val   = n_countdown;
        end else begin
            auto_pattern = tlcc_pkg::PAT_SECOND_AMB;
            first_val    = n_countdown;
            second_val   = n_countdown;
        end

        if (n_manual) begin
            n_light_pattern = n_manual_pattern;
            n_seg_tf        = '0;
            n_seg_of        = '0;
            n_seg_ts        = '0;
            n_seg_os        = '0;
        end else begin
            n_light_pattern = auto_pattern;
            n_seg_tf        = tlcc_pkg::f_seg(tlcc_pkg::f_tens(first_val));
            n_seg_of        = tlcc_pkg::f_seg(tlcc_pkg::f_ones(first_val));
            n_seg_ts        = tlcc_pkg::f_seg(tlcc_pkg::f_tens(second_val));
            n_seg_os        = tlcc_pkg::f_seg(tlcc_pkg::f_ones(second_val));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks_per_second   <= tlcc_pkg::TICKS_PER_SECOND_RST;
            r_cycle_start        <= tlcc_pkg::CYCLE_START_RST;
            r_tick_counter       <= '0;
            r_countdown          <= tlcc_pkg::CYCLE_START_RST;
            r_manual             <= 1'b0;
            r_manual_pattern     <= tlcc_pkg::PAT_FIRST_GO;
            r_button_was_pressed <= 1'b1;
            r_out_valid          <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_addr == tlcc_pkg::CFG_TICKS_PER_SECOND) begin
                    r_ticks_per_second <= i_cfg_data;
                end else begin
                    r_cycle_start <= i_cfg_data[6:0];
                end
            end
            if (in_accept) begin
                r_tick_counter       <= n_tick_counter;
                r_countdown          <= n_countdown;
                r_manual             <= n_manual;
                r_manual_pattern     <= n_manual_pattern;
                r_button_was_pressed <= n_button_was_pressed;
                r_out_valid          <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_light_pattern <= n_light_pattern;
            r_seg_tf        <= n_seg_tf;
            r_seg_of        <= n_seg_of;
            r_seg_ts        <= n_seg_ts;
            r_seg_os        <= n_seg_os;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_light_pattern   = r_light_pattern;
    assign o_seg_tens_first  = r_seg_tf;
    assign o_seg_ones_first  = r_seg_of;
    assign o_seg_tens_second = r_seg_ts;
    assign o_seg_ones_second = r_seg_os;
    assign o_manual_mode     = r_manual;
    assign o_seconds_left    = r_countdown;

    // Only an accepted tick may move the countdown.
    a_countdown_only_on_tick: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !(in_accept && i_operation == tlcc_pkg::OP_TICK) |=> $stable(r_countdown)
    ) else $error("countdown moved without a tick");

    // The manual pattern only ever alternates between the two straight patterns.
    a_manual_pattern_legal: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_manual_pattern == tlcc_pkg::PAT_FIRST_GO ||
        r_manual_pattern == tlcc_pkg::PAT_SECOND_GO
    ) else $error("manual pattern corrupted");

    // A result shown in manual mode has all digits blank.
    a_manual_blank: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_manual) |->
            (r_seg_tf == 7'd0 && r_seg_of == 7'd0 && r_seg_ts == 7'd0 && r_seg_os == 7'd0)
    ) else $error("segments lit in manual mode");

    // In manual mode the prescaler is frozen.
    a_prescaler_frozen: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (r_manual && !(in_accept && i_operation == tlcc_pkg::OP_MODE)) |=>
            $stable(r_tick_counter)
    ) else $error("prescaler moved in manual mode");

endmodule

`default_nettype wire
